FILE: design/nms_pkg.sv
// Shared types and constants for the neuron dot-product and sigmoid core.
`default_nettype none

package nms_pkg;

    localparam int FRAC_BITS = 12;
    localparam int POS_BITS = 28;
    localparam int SIG_W = 13;
    localparam int BIAS_W = 16;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_MODE = 2'd1;

    localparam logic SUM_MODE_FORWARD = 1'b0;
    localparam logic SUM_MODE_RAW = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: design/nms_front.sv
// Input side: multiplies each term and accumulates, handing finished sums to the queue.
`default_nettype none

module nms_front #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH = 40
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] activation,
    input  wire logic signed [DATA_WIDTH-1:0] weight,
    input  wire logic                         last_term,
    input  wire nms_pkg::q_status_t           q_status,
    output logic                              push,
    output logic signed [ACC_WIDTH-1:0]       push_data
);

    localparam int PROD_W = 2 * DATA_WIDTH;

    logic                       prod_valid_reg;
    logic                       prod_last_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic [nms_pkg::QCNT_W:0]   committed;

    // A sum still in the product stage already owns a queue slot.
    assign committed = (nms_pkg::QCNT_W + 1)'(q_status.count)
                     + (nms_pkg::QCNT_W + 1)'(prod_valid_reg & prod_last_reg);
    assign in_ready = committed < (nms_pkg::QCNT_W + 1)'(nms_pkg::QUEUE_DEPTH);

    assign acc_next = acc_reg + ACC_WIDTH'(prod_reg);
    assign push = prod_valid_reg & prod_last_reg;
    assign push_data = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            prod_valid_reg <= in_valid & in_ready;
            if (in_valid && in_ready)
            begin
                prod_last_reg <= last_term;
            end
            if (prod_valid_reg)
            begin
                acc_reg <= prod_last_reg ? '0 : acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= activation * weight;
        end
    end

endmodule

`default_nettype wire

FILE: design/nms_queue.sv
// Short queue of finished sums between the accumulator and the activation pipeline.
`default_nettype none

module nms_queue #(
    parameter int WIDTH = 40
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head,
    output nms_pkg::q_status_t    status
);

    logic [WIDTH-1:0]                slots_reg [0:nms_pkg::QUEUE_DEPTH-1];
    logic [nms_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [nms_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [nms_pkg::QCNT_W-1:0]      count_reg;
    logic [nms_pkg::QCNT_W-1:0]      count_next;

    assign head = slots_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/nms_back.sv
// Result side: bias and sigmoid interpolation, or raw rounding, then saturation and output register.
`default_nettype none

module nms_back #(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH = 40,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic signed [ACC_WIDTH-1:0]        head,
    input  wire nms_pkg::q_status_t                 q_status,
    output logic                                    pop,
    input  wire logic signed [nms_pkg::BIAS_W-1:0]  bias_value,
    input  wire logic                               sum_mode,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [DATA_WIDTH-1:0]            neuron_out,
    output logic                                    saturated
);

    localparam int IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int SCL_W = nms_pkg::POS_BITS + IDX_W;
    localparam int SUM_W = ((ACC_WIDTH > nms_pkg::POS_BITS + 1) ? ACC_WIDTH
                                                                : nms_pkg::POS_BITS + 1) + 1;
    localparam int RAW_W = ACC_WIDTH + 1;
    localparam int PROD_W = nms_pkg::SIG_W + nms_pkg::POS_BITS;

    localparam logic signed [SUM_W-1:0] SpanPos =
        SUM_W'(64'sd1 <<< (nms_pkg::POS_BITS - 1));
    localparam logic signed [SUM_W-1:0] SpanNeg = -SpanPos;
    localparam logic signed [RAW_W-1:0] RawRound =
        RAW_W'(64'sd1 <<< (nms_pkg::FRAC_BITS - 1));
    localparam logic signed [RAW_W-1:0] RawHi =
        RAW_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RAW_W-1:0] RawLo = -RawHi - 1;

    typedef logic [nms_pkg::SIG_W-1:0] sig_tab_t [0:SIGMOID_TABLE_DEPTH];

    typedef struct packed {
        logic                  interp;
        logic                  sat;
        logic [DATA_WIDTH-1:0] value;
    } res_info_t;

    // Unsigned quotient by shift and subtract, used only while the table is built.
    function automatic logic [63:0] div_u64(logic [63:0] num_in, logic [63:0] den_in);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int bit_pos = 63; bit_pos >= 0; bit_pos--)
        begin
            rem = {rem[63:0], num_in[bit_pos]};
            if (rem >= {1'b0, den_in})
            begin
                rem = rem - {1'b0, den_in};
                quo[bit_pos] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table points are round(4096 * sigmoid(x)) at equal steps over [-8, 8], built from a
    // Taylor series of e^(|x|/8) in Q31, a rounded reciprocal and three squarings.
    function automatic sig_tab_t build_sig_table();
        sig_tab_t    tab;
        longint      num;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        logic [63:0] den;
        int          i;
        for (int k = 0; k <= SIGMOID_TABLE_DEPTH; k++)
        begin
            num = 64'(16 * k) - 64'(8 * SIGMOID_TABLE_DEPTH);
            neg = (num < 0);
            mag = neg ? 64'(-num) : 64'(num);
            y = div_u64(mag << 28, 64'(SIGMOID_TABLE_DEPTH));
            term = 64'd1 << 31;
            sum = term;
            for (i = 1; i < 40 && term != 64'd0; i++)
            begin
                term = div_u64((term * y) >> 31, 64'(i));
                sum = sum + term;
            end
            r = div_u64((64'd1 << 62) + (sum >> 1), sum);
            for (i = 0; i < 3; i++)
            begin
                r = (r * r + (64'd1 << 30)) >> 31;
            end
            den = (64'd1 << 31) + r;
            if (neg)
            begin
                tab[k] = nms_pkg::SIG_W'(div_u64(r * 64'd4096 + (den >> 1), den));
            end
            else
            begin
                tab[k] = nms_pkg::SIG_W'(div_u64((64'd4096 << 31) + (den >> 1), den));
            end
        end
        return tab;
    endfunction

    localparam sig_tab_t SigTable = build_sig_table();

    logic en;

    logic                          a_valid_reg;
    logic signed [ACC_WIDTH-1:0]   a_acc_reg;

    logic                          b_valid_reg;
    res_info_t                     b_info_reg;
    logic [nms_pkg::POS_BITS-1:0]  b_offset_reg;

    logic                          c_valid_reg;
    res_info_t                     c_info_reg;
    logic [IDX_W-1:0]              c_idx_reg;
    logic [nms_pkg::POS_BITS-1:0]  c_frac_reg;

    logic                          d_valid_reg;
    res_info_t                     d_info_reg;
    logic [nms_pkg::SIG_W-1:0]     d_t0_reg;
    logic [nms_pkg::SIG_W-1:0]     d_diff_reg;
    logic [nms_pkg::POS_BITS-1:0]  d_frac_reg;

    logic                          e_valid_reg;
    res_info_t                     e_info_reg;
    logic [nms_pkg::SIG_W-1:0]     e_t0_reg;
    logic [PROD_W-1:0]             e_prod_reg;

    logic                          out_valid_reg;
    logic [DATA_WIDTH-1:0]         neuron_out_reg;
    logic                          saturated_reg;

    logic signed [SUM_W-1:0]       fwd_sum;
    logic signed [SUM_W-1:0]       fwd_offset;
    logic signed [RAW_W-1:0]       raw_shifted;
    res_info_t                     b_info_next;
    logic [SCL_W-1:0]              scaled;
    logic [nms_pkg::SIG_W-1:0]     tab_lo;
    logic [nms_pkg::SIG_W-1:0]     tab_hi;
    logic [PROD_W:0]               prod_rnd;
    logic [nms_pkg::SIG_W:0]       interp_val;
    logic [DATA_WIDTH-1:0]         neuron_out_next;

    assign en = !out_valid_reg || out_ready;
    assign pop = en && !q_status.empty;

    always_comb
    begin
        fwd_sum = SUM_W'(a_acc_reg) + (SUM_W'(bias_value) <<< nms_pkg::FRAC_BITS);
        fwd_offset = fwd_sum + SpanPos;
        raw_shifted = (RAW_W'(a_acc_reg) + RawRound) >>> nms_pkg::FRAC_BITS;
        b_info_next.interp = 1'b0;
        b_info_next.sat = 1'b0;
        b_info_next.value = '0;
        if (sum_mode == nms_pkg::SUM_MODE_RAW)
        begin
            if (raw_shifted > RawHi)
            begin
                b_info_next.sat = 1'b1;
                b_info_next.value = RawHi[DATA_WIDTH-1:0];
            end
            else if (raw_shifted < RawLo)
            begin
                b_info_next.sat = 1'b1;
                b_info_next.value = RawLo[DATA_WIDTH-1:0];
            end
            else
            begin
                b_info_next.value = raw_shifted[DATA_WIDTH-1:0];
            end
        end
        else if (fwd_sum < SpanNeg)
        begin
            b_info_next.sat = 1'b1;
            b_info_next.value = DATA_WIDTH'(SigTable[0]);
        end
        else if (fwd_sum >= SpanPos)
        begin
            b_info_next.sat = 1'b1;
            b_info_next.value = DATA_WIDTH'(SigTable[SIGMOID_TABLE_DEPTH]);
        end
        else
        begin
            b_info_next.interp = 1'b1;
        end
    end

    assign scaled = SCL_W'(b_offset_reg) * SCL_W'(SIGMOID_TABLE_DEPTH);
    assign tab_lo = SigTable[c_idx_reg];
    assign tab_hi = SigTable[(IDX_W + 1)'(c_idx_reg) + 1'b1];

    assign prod_rnd = (PROD_W + 1)'(e_prod_reg)
                    + ((PROD_W + 1)'(1) << (nms_pkg::POS_BITS - 1));
    assign interp_val = (nms_pkg::SIG_W + 1)'(e_t0_reg)
                      + (nms_pkg::SIG_W + 1)'(prod_rnd[PROD_W:nms_pkg::POS_BITS]);
    assign neuron_out_next = e_info_reg.interp ? DATA_WIDTH'(interp_val) : e_info_reg.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_acc_reg <= head;
            b_info_reg <= b_info_next;
            b_offset_reg <= fwd_offset[nms_pkg::POS_BITS-1:0];
            c_info_reg <= b_info_reg;
            c_idx_reg <= scaled[SCL_W-1:nms_pkg::POS_BITS];
            c_frac_reg <= scaled[nms_pkg::POS_BITS-1:0];
            d_info_reg <= c_info_reg;
            d_t0_reg <= tab_lo;
            d_diff_reg <= tab_hi - tab_lo;
            d_frac_reg <= c_frac_reg;
            e_info_reg <= d_info_reg;
            e_t0_reg <= d_t0_reg;
            e_prod_reg <= PROD_W'(d_diff_reg) * PROD_W'(d_frac_reg);
            neuron_out_reg <= neuron_out_next;
            saturated_reg <= e_info_reg.sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign neuron_out = neuron_out_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

FILE: design/neuron_mac_sigmoid_core.sv
// Top level of the single-neuron multiply-accumulate core with sigmoid activation.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    activation, weight, last_term
// output    out        out_valid/out_ready  neuron_out, saturated
// config    in         cfg_we               cfg_index, cfg_data
//
// One item is accepted every cycle while the sum queue has room; the multiplier and
// the accumulator adder each take one stage; registers a to e lead to the output register.
// The sigmoid table is a constant, so reset needs no clearing pass.
// A stalled output halts only the activation pipeline; the four-entry sum queue
// keeps the accumulator taking items until it fills.
`default_nettype none

module neuron_mac_sigmoid_core #(
    parameter int DATA_WIDTH = 16,
    parameter int MAX_TERMS = 256,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [nms_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [nms_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [DATA_WIDTH-1:0]         activation,
    input  wire logic signed [DATA_WIDTH-1:0]         weight,
    input  wire logic                                 last_term,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [DATA_WIDTH-1:0]              neuron_out,
    output logic                                      saturated
);

    localparam int ACC_WIDTH = 2 * DATA_WIDTH + $clog2(MAX_TERMS);

    logic signed [nms_pkg::BIAS_W-1:0] bias_value_reg;
    logic                              sum_mode_reg;

    nms_pkg::q_status_t                q_status;
    logic                              push;
    logic signed [ACC_WIDTH-1:0]       push_data;
    logic                              pop;
    logic [ACC_WIDTH-1:0]              head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_value_reg <= '0;
            sum_mode_reg <= nms_pkg::SUM_MODE_FORWARD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nms_pkg::CFG_BIAS_VALUE: bias_value_reg <= cfg_data;
                nms_pkg::CFG_SUM_MODE:   sum_mode_reg <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    nms_front #(
        .DATA_WIDTH(DATA_WIDTH),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .activation(activation),
        .weight    (weight),
        .last_term (last_term),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    nms_queue #(
        .WIDTH(ACC_WIDTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    nms_back #(
        .DATA_WIDTH         (DATA_WIDTH),
        .ACC_WIDTH          (ACC_WIDTH),
        .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .bias_value(bias_value_reg),
        .sum_mode  (sum_mode_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .neuron_out(neuron_out),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

FILE: verif/neuron_mac_sigmoid_core_tb.sv
// Self-checking testbench for the neuron multiply-accumulate and sigmoid core.
`timescale 1ns / 1ps

module neuron_mac_sigmoid_core_tb;
    import nms_pkg::*;

    localparam int DATA_WIDTH = 16;
    localparam int MAX_TERMS = 256;
    localparam int SIG_DEPTH = 256;
    localparam int ACC_W = 40;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  sat;
    } neuron_out_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] act;
        logic signed [DATA_WIDTH-1:0] wgt;
        logic                         last;
        logic                         mode;
        logic signed [BIAS_W-1:0]     bias;
        logic                         typed;
        logic [DATA_WIDTH-1:0]        out;
        logic                         sat;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [DATA_WIDTH-1:0] activation;
    logic signed [DATA_WIDTH-1:0] weight;
    logic last_term;
    logic out_valid;
    logic out_ready;
    logic signed [DATA_WIDTH-1:0] neuron_out;
    logic saturated;

    int sigmoid_points [0:SIG_DEPTH];
    logic signed [ACC_W-1:0] dot_sum;
    logic signed [BIAS_W-1:0] bias_q;
    logic raw_mode;
    neuron_out_t pending_outs [$];
    int mismatch_count;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    dir_row_t dir_rows [0:20] = '{
        '{16'h0000, 16'h0000, 1'b1, SUM_MODE_FORWARD, 16'h0000, 1'b1, 16'd2048, 1'b0},
        '{16'h7FFF, 16'h7FFF, 1'b1, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 16'h7FFF, 1'b1, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h1000, 16'h1000, 1'b1, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 16'h1000, 1'b1, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h1000, 1'b1, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h4000, 16'h2000, 1'b1, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h1000, 16'hF000, 1'b0, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h1234, 16'h0F0F, 1'b0, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'hFFFF, 16'hFFFF, 1'b1, SUM_MODE_FORWARD, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 1'b1, SUM_MODE_FORWARD, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 1'b1, SUM_MODE_FORWARD, 16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'hFFFF, 16'h0001, 1'b1, SUM_MODE_FORWARD, 16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'h1000, 16'h1000, 1'b1, SUM_MODE_RAW, 16'h3039, 1'b1, 16'h1000, 1'b0},
        '{16'h0800, 16'h0001, 1'b1, SUM_MODE_RAW, 16'h3039, 1'b1, 16'h0001, 1'b0},
        '{16'hF800, 16'h0001, 1'b1, SUM_MODE_RAW, 16'h3039, 1'b1, 16'h0000, 1'b0},
        '{16'hF7FF, 16'h0001, 1'b1, SUM_MODE_RAW, 16'h3039, 1'b1, 16'hFFFF, 1'b0},
        '{16'h8000, 16'h8000, 1'b1, SUM_MODE_RAW, 16'h3039, 1'b1, 16'h7FFF, 1'b1},
        '{16'h8000, 16'h7FFF, 1'b1, SUM_MODE_RAW, 16'h3039, 1'b1, 16'h8000, 1'b1},
        '{16'h7FFF, 16'h1000, 1'b1, SUM_MODE_RAW, 16'h3039, 1'b1, 16'h7FFF, 1'b0},
        '{16'h8000, 16'h1000, 1'b1, SUM_MODE_RAW, 16'h3039, 1'b1, 16'h8000, 1'b0}
    };

    neuron_mac_sigmoid_core #(
        .DATA_WIDTH(DATA_WIDTH),
        .MAX_TERMS(MAX_TERMS),
        .SIGMOID_TABLE_DEPTH(SIG_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .activation(activation),
        .weight(weight),
        .last_term(last_term),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .neuron_out(neuron_out),
        .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int sigmoid_point(int k);
        longint num;
        bit neg;
        longint unsigned mag;
        longint unsigned y;
        longint unsigned term;
        longint unsigned total;
        longint unsigned r;
        longint unsigned den;
        int i;
        num = 16 * k - 8 * SIG_DEPTH;
        neg = num < 0;
        mag = neg ? -num : num;
        y = (mag << 28) / SIG_DEPTH;
        term = 64'd1 << 31;
        total = term;
        for (i = 1; i < 40 && term != 0; i++)
        begin
            term = ((term * y) >> 31) / i;
            total += term;
        end
        r = ((64'd1 << 62) + total / 2) / total;
        for (i = 0; i < 3; i++)
            r = (r * r + (64'd1 << 30)) >> 31;
        den = (64'd1 << 31) + r;
        if (neg)
            return int'((r * 64'd4096 + den / 2) / den);
        return int'(((64'd4096 << 31) + den / 2) / den);
    endfunction

    function automatic neuron_out_t sigmoid_lookup(longint s);
        longint span;
        longint unsigned scaled;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned diff;
        neuron_out_t res;
        span = 64'sd1 <<< 27;
        if (s < -span)
        begin
            res.value = DATA_WIDTH'(sigmoid_points[0]);
            res.sat = 1'b1;
        end
        else if (s >= span)
        begin
            res.value = DATA_WIDTH'(sigmoid_points[SIG_DEPTH]);
            res.sat = 1'b1;
        end
        else
        begin
            scaled = longint'(s + span) * 64'd256;
            idx = scaled >> 28;
            if (idx >= SIG_DEPTH)
                idx = SIG_DEPTH - 1;
            frac = scaled & ((64'd1 << 28) - 1);
            diff = longint'(sigmoid_points[idx + 1] - sigmoid_points[idx]);
            res.value = DATA_WIDTH'(sigmoid_points[idx] + longint'((diff * frac
                        + (64'd1 << 27)) >> 28));
            res.sat = 1'b0;
        end
        return res;
    endfunction

    function automatic bit accumulate_term(logic signed [DATA_WIDTH-1:0] a,
                                           logic signed [DATA_WIDTH-1:0] w,
                                           logic l, output neuron_out_t res);
        longint prod;
        longint total;
        longint rounded;
        prod = longint'(a) * longint'(w);
        dot_sum = dot_sum + ACC_W'(prod);
        res = '0;
        if (!l)
            return 1'b0;
        total = longint'(dot_sum);
        dot_sum = '0;
        if (raw_mode == SUM_MODE_FORWARD)
        begin
            res = sigmoid_lookup(total + longint'(bias_q) * 4096);
        end
        else
        begin
            rounded = (total + 2048) >>> FRAC_BITS;
            res.sat = 1'b0;
            if (rounded > 32767)
            begin
                rounded = 32767;
                res.sat = 1'b1;
            end
            if (rounded < -32768)
            begin
                rounded = -32768;
                res.sat = 1'b1;
            end
            res.value = DATA_WIDTH'(rounded);
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    task automatic send_item(input logic signed [DATA_WIDTH-1:0] a,
                             input logic signed [DATA_WIDTH-1:0] w, input logic l,
                             input logic typed, input logic [DATA_WIDTH-1:0] t_out,
                             input logic t_sat);
        neuron_out_t res;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        activation <= a;
        weight <= w;
        last_term <= l;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        if (accumulate_term(a, w, l, res))
        begin
            if (typed)
            begin
                res.value = t_out;
                res.sat = t_sat;
            end
            pending_outs.insert(pending_outs.size(), res);
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_outs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_BIAS_VALUE)
            bias_q = data;
        else if (idx == CFG_SUM_MODE)
            raw_mode = data[0];
        @(negedge clk);
    endtask

    task automatic configure_core(input logic mode, input logic [BIAS_W-1:0] bias,
                                  input bit spare);
        write_reg(CFG_BIAS_VALUE, bias);
        write_reg(CFG_SUM_MODE, {15'($urandom), mode});
        if (spare)
        begin
            write_reg(CFG_SPARE_A, 16'($urandom));
            write_reg(CFG_SPARE_B, 16'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_operand(int kind, bit is_weight);
        case (kind)
            0: return DATA_WIDTH'($urandom);
            1: return is_weight ? DATA_WIDTH'(int'($urandom_range(0, 4095)) - 2048)
                                : DATA_WIDTH'(int'($urandom_range(0, 16383)) - 8192);
            2: return is_weight ? DATA_WIDTH'($urandom)
                                : DATA_WIDTH'(int'($urandom_range(0, 2047)) - 1024);
            default:
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
        endcase
    endfunction

    always @(negedge clk)
        out_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        neuron_out_t exp_res;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_outs.size() == 0)
            begin
                report_mismatch("unexpected item", neuron_out, 0);
            end
            else
            begin
                exp_res = pending_outs.pop_front();
                if (neuron_out !== exp_res.value)
                    report_mismatch("neuron_out", neuron_out, $signed(exp_res.value));
                if (saturated !== exp_res.sat)
                    report_mismatch("saturated", saturated, exp_res.sat);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("neuron_mac_sigmoid_core_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int r;
        int n;
        int len;
        int kind;
        int count;
        logic mode;
        logic [BIAS_W-1:0] bias;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        activation = '0;
        weight = '0;
        last_term = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        dot_sum = '0;
        bias_q = '0;
        raw_mode = SUM_MODE_FORWARD;
        for (n = 0; n <= SIG_DEPTH; n++)
            sigmoid_points[n] = sigmoid_point(n);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].mode != raw_mode || dir_rows[i].bias != bias_q)
            begin
                wait_idle();
                configure_core(dir_rows[i].mode, dir_rows[i].bias, 1'b0);
            end
            send_item(dir_rows[i].act, dir_rows[i].wgt, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].out, dir_rows[i].sat);
        end

        for (ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            send_idle_pct = (ph % 4 == 1) ? 60 : (ph % 4 == 3) ? 17 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 60 : (ph % 4 == 3) ? 17 : 0;
            case (ph)
                0: begin mode = SUM_MODE_FORWARD; bias = 16'h0000; end
                2: begin mode = SUM_MODE_FORWARD; bias = 16'h7FFF; end
                3: begin mode = SUM_MODE_FORWARD; bias = 16'h8000; end
                1, 4, 7: begin mode = SUM_MODE_RAW; bias = 16'($urandom); end
                default: begin mode = SUM_MODE_FORWARD; bias = 16'($urandom); end
            endcase
            configure_core(mode, bias, 1'b1);

            count = 0;
            if (ph == 1)
            begin
                for (n = 0; n < MAX_TERMS; n++)
                    send_item(16'h8000, 16'h8000, n == MAX_TERMS - 1, 1'b0, '0, 1'b0);
                count = MAX_TERMS;
            end
            while (count < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                len = (r < 70) ? $urandom_range(1, 8) :
                      (r < 99) ? $urandom_range(9, 32) : $urandom_range(33, MAX_TERMS);
                kind = $urandom_range(0, 3);
                for (n = 0; n < len; n++)
                    send_item(pick_operand(kind, 1'b0), pick_operand(kind, 1'b1),
                              n == len - 1, 1'b0, '0, 1'b0);
                count += len;
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("neuron_mac_sigmoid_core_tb: clean");
        else
            $display("neuron_mac_sigmoid_core_tb: errors");
        $finish;
    end

endmodule
